@@ hdl/mvna_pkg.sv @@
package mvna_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_TRI   = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TRI_POS,
    S_TRI_DIFF,
    S_TRI_MUL,
    S_TRI_CROSS,
    S_SUM_RD,
    S_SUM_WR,
    S_RD_ISSUE,
    S_RD_DATA,
    S_RD_WAIT
  } top_state_e;

  typedef enum logic [2:0] {
    U_IDLE,
    U_NORM,
    U_SQ,
    U_SQRT,
    U_DIV_INIT,
    U_DIV,
    U_DONE
  } uv_state_e;

  // One vertex memory word.
  typedef struct packed {
    logic        flag;
    logic [15:0] gz;
    logic [15:0] gy;
    logic [15:0] gx;
    logic [15:0] pz;
    logic [15:0] py;
    logic [15:0] px;
  } vtx_t;

  typedef struct packed {
    logic        done;
    logic        deg;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
  } unit_res_t;

  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 17;

endpackage

@@ hdl/mvna_unitvec.sv @@
module mvna_unitvec #(
  parameter int SUM_WIDTH = 48
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [SUM_WIDTH-1:0]      sum_x_i,
  input  logic [SUM_WIDTH-1:0]      sum_y_i,
  input  logic [SUM_WIDTH-1:0]      sum_z_i,
  output mvna_pkg::unit_res_t       res_o
);

  localparam logic [SUM_WIDTH-1:0] LIM_HI = SUM_WIDTH'(64'd1 << 30);
  localparam logic [SUM_WIDTH-1:0] LIM_LO = SUM_WIDTH'(64'd1 << 29);

  mvna_pkg::uv_state_e state_q, state_d;

  logic [5:0]           cnt_q;
  logic [1:0]           comp_q;
  logic [SUM_WIDTH-1:0] m_q [3];
  logic [SUM_WIDTH-1:0] maxm_q;
  logic [2:0]           neg_q;
  logic [63:0]          q_q;
  logic [63:0]          root_q;
  logic [63:0]          bit_q;
  logic [47:0]          rem_q;
  logic [48:0]          dsh_q;
  logic [15:0]          quo_q;
  logic [15:0]          res_q [3];
  logic                 deg_q;

  logic [SUM_WIDTH-1:0] mag_in [3];
  logic [SUM_WIDTH-1:0] maxm_in;
  logic [63:0]          rb;
  logic                 sq_ge;
  logic                 div_ge;
  logic [16:0]          quo_d;
  logic [59:0]          sq;

  function automatic logic [SUM_WIDTH-1:0] mag(logic [SUM_WIDTH-1:0] s);
    return s[SUM_WIDTH-1] ? (~s + 1'b1) : s;
  endfunction

  function automatic logic [15:0] fix(logic [16:0] q, logic n);
    logic [15:0] v;
    v = (q > 17'd32767) ? 16'd32767 : {1'b0, q[14:0]};
    return n ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    mag_in[0] = mag(sum_x_i);
    mag_in[1] = mag(sum_y_i);
    mag_in[2] = mag(sum_z_i);
    maxm_in   = mag_in[0];
    if (mag_in[1] > maxm_in) maxm_in = mag_in[1];
    if (mag_in[2] > maxm_in) maxm_in = mag_in[2];
    rb     = root_q + bit_q;
    sq_ge  = q_q >= rb;
    div_ge = {1'b0, rem_q} >= dsh_q;
    quo_d  = {quo_q, div_ge};
    sq     = m_q[comp_q][29:0] * m_q[comp_q][29:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mvna_pkg::U_IDLE: begin
        if (start_i) state_d = (maxm_in == '0) ? mvna_pkg::U_DONE : mvna_pkg::U_NORM;
      end
      mvna_pkg::U_NORM: begin
        if (maxm_q < LIM_HI && maxm_q >= LIM_LO) state_d = mvna_pkg::U_SQ;
      end
      mvna_pkg::U_SQ: begin
        if (comp_q == 2'd2) state_d = mvna_pkg::U_SQRT;
      end
      mvna_pkg::U_SQRT: begin
        if (cnt_q == 6'(mvna_pkg::SQRT_STEPS - 1)) state_d = mvna_pkg::U_DIV_INIT;
      end
      mvna_pkg::U_DIV_INIT: state_d = mvna_pkg::U_DIV;
      mvna_pkg::U_DIV: begin
        if (cnt_q == 6'(mvna_pkg::DIV_STEPS - 1)) begin
          state_d = (comp_q == 2'd2) ? mvna_pkg::U_DONE : mvna_pkg::U_DIV_INIT;
        end
      end
      mvna_pkg::U_DONE: state_d = mvna_pkg::U_IDLE;
      default: state_d = mvna_pkg::U_IDLE;
    endcase
  end

  always_comb begin
    res_o.done = (state_q == mvna_pkg::U_DONE);
    res_o.deg  = deg_q;
    res_o.nx   = res_q[0];
    res_o.ny   = res_q[1];
    res_o.nz   = res_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mvna_pkg::U_IDLE;
      cnt_q   <= '0;
      comp_q  <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        mvna_pkg::U_SQ: begin
          comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
          cnt_q  <= '0;
        end
        mvna_pkg::U_SQRT: cnt_q <= (state_d == state_q) ? cnt_q + 6'd1 : 6'd0;
        mvna_pkg::U_DIV: begin
          if (cnt_q == 6'(mvna_pkg::DIV_STEPS - 1)) begin
            cnt_q  <= '0;
            comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        default: cnt_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      mvna_pkg::U_IDLE: begin
        if (start_i) begin
          m_q[0] <= mag_in[0];
          m_q[1] <= mag_in[1];
          m_q[2] <= mag_in[2];
          maxm_q <= maxm_in;
          neg_q  <= {sum_z_i[SUM_WIDTH-1], sum_y_i[SUM_WIDTH-1], sum_x_i[SUM_WIDTH-1]};
          deg_q  <= (maxm_in == '0);
          q_q    <= '0;
          res_q[0] <= '0;
          res_q[1] <= '0;
          res_q[2] <= '0;
        end
      end
      mvna_pkg::U_NORM: begin
        // Bring the largest magnitude into [2^29, 2^30), one bit a cycle.
        if (maxm_q >= LIM_HI) begin
          maxm_q <= maxm_q >> 1;
          m_q[0] <= m_q[0] >> 1;
          m_q[1] <= m_q[1] >> 1;
          m_q[2] <= m_q[2] >> 1;
        end else if (maxm_q < LIM_LO) begin
          maxm_q <= maxm_q << 1;
          m_q[0] <= m_q[0] << 1;
          m_q[1] <= m_q[1] << 1;
          m_q[2] <= m_q[2] << 1;
        end
      end
      mvna_pkg::U_SQ: begin
        q_q    <= q_q + {4'd0, sq};
        root_q <= '0;
        bit_q  <= 64'd1 << 62;
      end
      mvna_pkg::U_SQRT: begin
        if (sq_ge) begin
          q_q    <= q_q - rb;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      mvna_pkg::U_DIV_INIT: begin
        rem_q <= {2'd0, m_q[comp_q][29:0], 16'd0} + {16'd0, root_q[31:0]};
        dsh_q <= {root_q[31:0], 17'd0};
        quo_q <= '0;
      end
      mvna_pkg::U_DIV: begin
        if (div_ge) rem_q <= rem_q - dsh_q[47:0];
        dsh_q <= dsh_q >> 1;
        quo_q <= quo_d[15:0];
        if (cnt_q == 6'(mvna_pkg::DIV_STEPS - 1)) res_q[comp_q] <= fix(quo_d, neg_q[comp_q]);
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/mesh_vertex_normal_accumulator_unit.sv @@
// Channel   | Handshake              | Payload
// ----------+------------------------+-------------------------------------------
// item in   | start high, busy low   | command_i, vertex_index_i, pos_*, given_*,
//           |                        | normal_given_i, corner_a/b/c_i
// result    | out_valid_o, 1 cycle   | out_index_o, out_n*_o, degenerate_o
//
// A vertex write, an ignored command and an out-of-range item keep busy low.
// A triangle makes three reads of the vertex memory, six products on one
// shared multiplier, then a read and a write of the sum memory for each
// corner that has no given normal.
// A read of a given normal takes it from the vertex memory and a read of a
// zero sum skips the scaling; a scaled read runs the one-bit normalizing shift
// (up to 29 steps), the 32-step square root and a divide for each component.
// Reset clears control state only.
// The receiver cannot stall: each result is shown for exactly one cycle.
module mesh_vertex_normal_accumulator_unit #(
  parameter int MAX_VERTICES = 1024,
  parameter int SUM_WIDTH    = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command_i,
  input  logic [9:0]         vertex_index_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] pos_z_i,
  input  logic signed [15:0] given_nx_i,
  input  logic signed [15:0] given_ny_i,
  input  logic signed [15:0] given_nz_i,
  input  logic               normal_given_i,
  input  logic [9:0]         corner_a_i,
  input  logic [9:0]         corner_b_i,
  input  logic [9:0]         corner_c_i,
  output logic               out_valid_o,
  output logic [9:0]         out_index_o,
  output logic signed [15:0] out_nx_o,
  output logic signed [15:0] out_ny_o,
  output logic signed [15:0] out_nz_o,
  output logic               degenerate_o
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int SW = SUM_WIDTH;

  mvna_pkg::top_state_e state_q, state_d;

  logic [2:0]          k_q;
  logic [9:0]          idx_q;
  logic [9:0]          corner_q [3];
  logic signed [15:0]  pos_q [3][3];
  logic [2:0]          flag_q;
  logic signed [16:0]  u_q [3];
  logic signed [16:0]  v_q [3];
  logic signed [33:0]  prod_q [6];
  logic signed [34:0]  n_q [3];

  mvna_pkg::vtx_t      vmem [MAX_VERTICES];
  logic [3*SW-1:0]     smem [MAX_VERTICES];
  mvna_pkg::vtx_t      vrd_q;
  logic [3*SW-1:0]     srd_q;

  logic                out_valid_q;
  logic [9:0]          out_index_q;
  logic [15:0]         out_nx_q, out_ny_q, out_nz_q;
  logic                deg_q;

  logic                accept;
  logic                idx_ok;
  logic                tri_ok;
  logic                vmem_we, vmem_re, smem_we, smem_re, uv_start;
  logic [AW-1:0]       vmem_addr, smem_addr;
  logic [3*SW-1:0]     smem_wdata;
  mvna_pkg::vtx_t      vmem_wdata;
  logic [9:0]          corner_k;
  logic signed [16:0]  mul_a, mul_b;
  mvna_pkg::unit_res_t uv_res;

  function automatic logic [AW-1:0] to_addr(logic [9:0] i);
    logic [31:0] t;
    t = {22'd0, i};
    return t[AW-1:0];
  endfunction

  function automatic logic in_range(logic [9:0] i);
    return {22'd0, i} < 32'(MAX_VERTICES);
  endfunction

  function automatic logic [SW-1:0] sat_add(logic [SW-1:0] s, logic signed [34:0] c);
    logic signed [SW:0] t;
    t = $signed({s[SW-1], s}) + $signed({{(SW-34){c[34]}}, c});
    if (t[SW] != t[SW-1]) begin
      return t[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
    return t[SW-1:0];
  endfunction

  assign busy   = (state_q != mvna_pkg::S_IDLE);
  assign accept = start && !busy;
  assign idx_ok = in_range(vertex_index_i);
  assign tri_ok = in_range(corner_a_i) && in_range(corner_b_i) && in_range(corner_c_i);

  always_comb begin
    unique case (k_q)
      3'd0:    corner_k = corner_q[0];
      3'd1:    corner_k = corner_q[1];
      default: corner_k = corner_q[2];
    endcase
  end

  // Operand pairs of the cross product, one product a cycle.
  always_comb begin
    unique case (k_q)
      3'd0:    begin mul_a = u_q[1]; mul_b = v_q[2]; end
      3'd1:    begin mul_a = u_q[2]; mul_b = v_q[1]; end
      3'd2:    begin mul_a = u_q[2]; mul_b = v_q[0]; end
      3'd3:    begin mul_a = u_q[0]; mul_b = v_q[2]; end
      3'd4:    begin mul_a = u_q[0]; mul_b = v_q[1]; end
      default: begin mul_a = u_q[1]; mul_b = v_q[0]; end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mvna_pkg::S_IDLE: begin
        if (accept) begin
          unique case (command_i)
            mvna_pkg::CMD_TRI:  if (tri_ok) state_d = mvna_pkg::S_TRI_POS;
            mvna_pkg::CMD_READ: if (idx_ok) state_d = mvna_pkg::S_RD_ISSUE;
            default: ;
          endcase
        end
      end
      mvna_pkg::S_TRI_POS:   if (k_q == 3'd3) state_d = mvna_pkg::S_TRI_DIFF;
      mvna_pkg::S_TRI_DIFF:  state_d = mvna_pkg::S_TRI_MUL;
      mvna_pkg::S_TRI_MUL:   if (k_q == 3'd5) state_d = mvna_pkg::S_TRI_CROSS;
      mvna_pkg::S_TRI_CROSS: state_d = mvna_pkg::S_SUM_RD;
      mvna_pkg::S_SUM_RD: begin
        if (!flag_q[k_q[1:0]]) state_d = mvna_pkg::S_SUM_WR;
        else if (k_q == 3'd2)  state_d = mvna_pkg::S_IDLE;
      end
      mvna_pkg::S_SUM_WR: begin
        state_d = (k_q == 3'd2) ? mvna_pkg::S_IDLE : mvna_pkg::S_SUM_RD;
      end
      mvna_pkg::S_RD_ISSUE: state_d = mvna_pkg::S_RD_DATA;
      mvna_pkg::S_RD_DATA: begin
        state_d = vrd_q.flag ? mvna_pkg::S_IDLE : mvna_pkg::S_RD_WAIT;
      end
      mvna_pkg::S_RD_WAIT: if (uv_res.done) state_d = mvna_pkg::S_IDLE;
      default: state_d = mvna_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    vmem_we    = 1'b0;
    vmem_re    = 1'b0;
    smem_we    = 1'b0;
    smem_re    = 1'b0;
    uv_start   = 1'b0;
    vmem_addr  = to_addr(idx_q);
    smem_addr  = to_addr(idx_q);
    smem_wdata = '0;
    vmem_wdata = {normal_given_i, given_nz_i, given_ny_i, given_nx_i,
                  pos_z_i, pos_y_i, pos_x_i};
    unique case (state_q)
      mvna_pkg::S_IDLE: begin
        vmem_addr = to_addr(vertex_index_i);
        smem_addr = to_addr(vertex_index_i);
        // Writing a vertex clears its sums in the same cycle.
        if (accept && command_i == mvna_pkg::CMD_WRITE && idx_ok) begin
          vmem_we = 1'b1;
          smem_we = 1'b1;
        end
      end
      mvna_pkg::S_TRI_POS: begin
        vmem_addr = to_addr(corner_k);
        vmem_re   = (k_q != 3'd3);
      end
      mvna_pkg::S_SUM_RD: begin
        smem_addr = to_addr(corner_k);
        smem_re   = !flag_q[k_q[1:0]];
      end
      mvna_pkg::S_SUM_WR: begin
        smem_addr  = to_addr(corner_k);
        smem_we    = 1'b1;
        smem_wdata = {sat_add(srd_q[3*SW-1:2*SW], n_q[2]),
                      sat_add(srd_q[2*SW-1:SW],   n_q[1]),
                      sat_add(srd_q[SW-1:0],      n_q[0])};
      end
      mvna_pkg::S_RD_ISSUE: begin
        vmem_re = 1'b1;
        smem_re = 1'b1;
      end
      mvna_pkg::S_RD_DATA: uv_start = !vrd_q.flag;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (vmem_we) vmem[vmem_addr] <= vmem_wdata;
    if (vmem_re) vrd_q <= vmem[vmem_addr];
  end

  always_ff @(posedge clk_i) begin
    if (smem_we) smem[smem_addr] <= smem_wdata;
    if (smem_re) srd_q <= smem[smem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mvna_pkg::S_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= 1'b0;
      unique case (state_q)
        mvna_pkg::S_IDLE: begin
          k_q <= '0;
          if (accept && command_i == mvna_pkg::CMD_READ && !idx_ok) out_valid_q <= 1'b1;
        end
        mvna_pkg::S_TRI_POS, mvna_pkg::S_TRI_MUL: begin
          k_q <= (state_d == state_q) ? k_q + 3'd1 : 3'd0;
        end
        mvna_pkg::S_SUM_RD: if (flag_q[k_q[1:0]]) k_q <= k_q + 3'd1;
        mvna_pkg::S_SUM_WR: k_q <= k_q + 3'd1;
        mvna_pkg::S_RD_DATA: if (vrd_q.flag) out_valid_q <= 1'b1;
        mvna_pkg::S_RD_WAIT: if (uv_res.done) out_valid_q <= 1'b1;
        default: k_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      mvna_pkg::S_IDLE: begin
        if (accept) begin
          idx_q       <= vertex_index_i;
          corner_q[0] <= corner_a_i;
          corner_q[1] <= corner_b_i;
          corner_q[2] <= corner_c_i;
          out_index_q <= vertex_index_i;
          out_nx_q    <= '0;
          out_ny_q    <= '0;
          out_nz_q    <= '0;
          deg_q       <= 1'b1;
        end
      end
      mvna_pkg::S_TRI_POS: begin
        if (k_q != 3'd0) begin
          pos_q[k_q[1:0] - 2'd1][0] <= $signed(vrd_q.px);
          pos_q[k_q[1:0] - 2'd1][1] <= $signed(vrd_q.py);
          pos_q[k_q[1:0] - 2'd1][2] <= $signed(vrd_q.pz);
          flag_q[k_q[1:0] - 2'd1]   <= vrd_q.flag;
        end
      end
      mvna_pkg::S_TRI_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          u_q[i] <= 17'(pos_q[1][i]) - 17'(pos_q[0][i]);
          v_q[i] <= 17'(pos_q[2][i]) - 17'(pos_q[0][i]);
        end
      end
      mvna_pkg::S_TRI_MUL: prod_q[k_q] <= mul_a * mul_b;
      mvna_pkg::S_TRI_CROSS: begin
        n_q[0] <= 35'(prod_q[0]) - 35'(prod_q[1]);
        n_q[1] <= 35'(prod_q[2]) - 35'(prod_q[3]);
        n_q[2] <= 35'(prod_q[4]) - 35'(prod_q[5]);
      end
      mvna_pkg::S_RD_DATA: begin
        if (vrd_q.flag) begin
          out_nx_q <= vrd_q.gx;
          out_ny_q <= vrd_q.gy;
          out_nz_q <= vrd_q.gz;
          deg_q    <= 1'b0;
        end
      end
      mvna_pkg::S_RD_WAIT: begin
        if (uv_res.done) begin
          out_nx_q <= uv_res.nx;
          out_ny_q <= uv_res.ny;
          out_nz_q <= uv_res.nz;
          deg_q    <= uv_res.deg;
        end
      end
      default: ;
    endcase
  end

  mvna_unitvec #(
    .SUM_WIDTH(SUM_WIDTH)
  ) u_unitvec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (uv_start),
    .sum_x_i (srd_q[SW-1:0]),
    .sum_y_i (srd_q[2*SW-1:SW]),
    .sum_z_i (srd_q[3*SW-1:2*SW]),
    .res_o   (uv_res)
  );

  assign out_valid_o  = out_valid_q;
  assign out_index_o  = out_index_q;
  assign out_nx_o     = $signed(out_nx_q);
  assign out_ny_o     = $signed(out_ny_q);
  assign out_nz_o     = $signed(out_nz_q);
  assign degenerate_o = deg_q;

endmodule

@@ hdl/mvna_checker.sv @@
module mvna_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic [1:0]         command_i,
  input logic               out_valid_o,
  input logic signed [15:0] out_nx_o,
  input logic signed [15:0] out_ny_o,
  input logic signed [15:0] out_nz_o,
  input logic               degenerate_o
);

  // A degenerate result always carries a zero normal.
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> out_nx_o == 0 && out_ny_o == 0 && out_nz_o == 0)
    else $error("degenerate result with nonzero normal");

  // A vertex write finishes in the cycle it is taken.
  a_write_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && command_i == mvna_pkg::CMD_WRITE |=> !busy)
    else $error("vertex write left the block busy");

  // The block only turns busy because an item was taken.
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an item");

  // A triangle never produces a result in the cycle after it is taken.
  a_tri_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && command_i == mvna_pkg::CMD_TRI |=> !out_valid_o)
    else $error("triangle produced a result");

endmodule

bind mesh_vertex_normal_accumulator_unit mvna_checker u_mvna_checker (.*);
